### rtl/core/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multi-slot timer
// Beat layouts for both channels, the command codes and the per-cell beat that
// travels down the row of timer cells.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MASK_W        = 8;
    localparam int COUNT_W       = 4;
    localparam int PERIOD_W      = 32;

    // Repeat kind code that marks a slot as single shot.
    localparam logic REPEAT_ONCE = 1'b0;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_REMOVE = 2'd2
    } mst_mode_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [2:0]          slot;
        logic [PERIOD_W-1:0] period;
        logic                repeat_req;
    } mst_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  expired_mask;
        logic [COUNT_W-1:0] listed_count;
    } mst_evt_t;

    // What one cell hands to the next: the command and the partial result.
    typedef struct packed {
        mst_cmd_t           cmd;
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
    } mst_beat_t;

endpackage

### rtl/core/mst_cell.sv
// ----------------------------------------------------------------------------
// mst_cell: one timer slot of the cell row
// Holds the state of one slot, applies the passing command to it, adds its
// expiry bit and listed flag to the partial result and hands the beat on.
// ----------------------------------------------------------------------------
module mst_cell
    import mst_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  mst_beat_t in_beat,
    output logic      out_valid,
    output mst_beat_t out_beat
);

    // Only the first eight slots can be named by the 3-bit slot field.
    localparam bit               ADDRESSABLE = (CELL_IDX < MASK_W);
    localparam logic [2:0]       SLOT_CODE   = 3'(CELL_IDX % MASK_W);
    localparam logic [MASK_W-1:0] MASK_BIT   =
        ADDRESSABLE ? (MASK_W'(1) << SLOT_CODE) : '0;

    logic                listed_reg,    listed_next;
    logic                running_reg,   running_next;
    logic                periodic_reg,  periodic_next;
    logic [PERIOD_W-1:0] remaining_reg, remaining_next;
    logic [PERIOD_W-1:0] reload_reg,    reload_next;
    logic                valid_reg;
    mst_beat_t           beat_reg,      beat_next;

    logic                hit;
    logic                expire;
    logic [PERIOD_W-1:0] rem_dec;
    logic [PERIOD_W-1:0] load_val;

    assign hit      = ADDRESSABLE && (in_beat.cmd.slot == SLOT_CODE);
    assign rem_dec  = remaining_reg - PERIOD_W'(1);
    assign load_val = (in_beat.cmd.period == '0) ? PERIOD_W'(1) : in_beat.cmd.period;

    always_comb
    begin
        listed_next    = listed_reg;
        running_next   = running_reg;
        periodic_next  = periodic_reg;
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        expire         = 1'b0;
        if (advance && in_valid)
        begin
            case (in_beat.cmd.mode)
                MODE_TICK:
                begin
                    if (listed_reg && running_reg)
                    begin
                        remaining_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            expire = 1'b1;
                            if (!periodic_reg)
                            begin
                                running_next = 1'b0;
                                listed_next  = 1'b0;
                            end
                            else
                            begin
                                remaining_next = reload_reg;
                            end
                        end
                    end
                end
                MODE_START:
                begin
                    if (hit)
                    begin
                        reload_next    = load_val;
                        remaining_next = load_val;
                        periodic_next  = (in_beat.cmd.repeat_req != REPEAT_ONCE);
                        running_next   = 1'b1;
                        listed_next    = 1'b1;
                    end
                end
                MODE_REMOVE:
                begin
                    if (hit)
                    begin
                        listed_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        beat_next       = in_beat;
        beat_next.mask  = in_beat.mask | (expire ? MASK_BIT : '0);
        beat_next.count = (listed_next && (in_beat.count != '1)) ?
                          in_beat.count + COUNT_W'(1) : in_beat.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listed_reg    <= 1'b0;
            running_reg   <= 1'b0;
            periodic_reg  <= 1'b0;
            remaining_reg <= '0;
            reload_reg    <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            listed_reg    <= listed_next;
            running_reg   <= running_next;
            periodic_reg  <= periodic_next;
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            if (advance)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // A listed, running slot always has ticks left to count.
    a_live_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (listed_reg && running_reg) |-> (remaining_reg != '0))
        else $error("listed running slot with zero countdown");

endmodule

### rtl/core/multi_slot_oneshot_periodic_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_oneshot_periodic_timer: row of countdown timer slots
// Single-shot or periodic countdown timers, one per cell. Each command beat
// (tick, start, remove) walks down the row, one cell per cycle while the row
// is not held, and leaves with the expiry mask and the number of listed slots.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Beat       Direction  Content
//  -------  -------------------  ---------  ---------  ---------------------------------
//  cmd      cmd_valid/cmd_ready  mst_cmd_t  in         mode, slot, period, repeat_req
//  evt      evt_valid/evt_ready  mst_evt_t  out        expired_mask, listed_count
//
// One command beat is taken in every cycle in which the row is not held; its
// result beat passes through one register per cell and then the output
// register before it appears on evt.
// Every cell sees the commands in order, so each slot's state is up to date
// when a beat reaches it and the partial mask and count gather exactly the
// slot states the beat left behind.
// When a result waits in the output register and evt_ready is low, the whole
// row holds and cmd_ready drops in the same cycle.
// Reset clears every slot (not listed, not running) and empties the row.
//
module multi_slot_oneshot_periodic_timer
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  mst_cmd_t cmd,
    output logic     evt_valid,
    input  logic     evt_ready,
    output mst_evt_t evt
);

    localparam int               CNT_MAX    = (NUM_SLOTS > 15) ? 15 : NUM_SLOTS;
    localparam logic [MASK_W-1:0] MASK_LIMIT =
        (NUM_SLOTS >= MASK_W) ? '1 : MASK_W'((1 << NUM_SLOTS) - 1);

    logic      chain_valid [NUM_SLOTS+1];
    mst_beat_t chain_beat  [NUM_SLOTS+1];
    logic      advance;
    logic      evt_valid_reg;
    mst_evt_t  evt_reg;

    // The row moves whenever the output register is free or being emptied.
    assign advance   = !evt_valid_reg || evt_ready;
    assign cmd_ready = advance;

    // The head of the row takes the command beat with an empty partial result.
    assign chain_valid[0]      = cmd_valid;
    assign chain_beat[0].cmd   = cmd;
    assign chain_beat[0].mask  = '0;
    assign chain_beat[0].count = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        mst_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[g]),
            .in_beat   (chain_beat[g]),
            .out_valid (chain_valid[g+1]),
            .out_beat  (chain_beat[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            evt_valid_reg <= chain_valid[NUM_SLOTS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            evt_reg.expired_mask <= chain_beat[NUM_SLOTS].mask;
            evt_reg.listed_count <= chain_beat[NUM_SLOTS].count;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    // No slot beyond the array can ever report an expiry.
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> ((evt.expired_mask & ~MASK_LIMIT) == '0))
        else $error("expiry reported for a slot that does not exist");

    // The listed count cannot exceed the number of slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.listed_count <= COUNT_W'(CNT_MAX)))
        else $error("listed count above slot count");

    // A held result must freeze the row and block new commands.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_ready) |-> !cmd_ready)
        else $error("command taken while result is stalled");

    // Once a result is held, the row stays frozen into the next cycle too.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_ready) |=> evt_valid)
        else $error("stalled result lost");

endmodule
